// ===== src/hsl_to_rgb_converter_top_defines.svh =====
// assertion macros for the hsl to rgb converter
// expects clk and rst_n in the scope where a macro is used
`ifndef HSL_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define HSL_ASSERT_LATER(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

// ===== src/hsl2rgb_pkg.sv =====
// shared types, constants and helpers for the hsl to rgb converter
// no dependencies
`default_nettype none

package hsl2rgb_pkg;

  // hue is in sixteenths of a degree
  localparam logic [12:0] HUE_FULL    = 13'd5760;
  localparam logic [9:0]  SECTOR_SPAN = 10'd960;

  // floor(y / 255) = (y * DIV255_MAGIC) >> DIV255_SHIFT for any 16-bit y
  localparam logic [15:0] DIV255_MAGIC = 16'h8081;
  localparam int          DIV255_SHIFT = 23;

  localparam logic [7:0]  CHAN_MAX   = 8'hff;
  localparam int          PIPE_DEPTH = 7;

  // sixty-degree sectors, named by the largest then the secondary channel
  typedef enum logic [2:0] {
    SEC_R_G = 3'd0,
    SEC_G_R = 3'd1,
    SEC_G_B = 3'd2,
    SEC_B_G = 3'd3,
    SEC_B_R = 3'd4,
    SEC_R_B = 3'd5
  } sector_t;

  function automatic logic [12:0] sector_base(input sector_t sec);
    logic [12:0] base;
    base = 13'd0;
    unique case (sec)
      SEC_R_G: base = 13'd0;
      SEC_G_R: base = 13'd960;
      SEC_G_B: base = 13'd1920;
      SEC_B_G: base = 13'd2880;
      SEC_B_R: base = 13'd3840;
      SEC_R_B: base = 13'd4800;
      default: base = 13'd0;
    endcase
    return base;
  endfunction

  // odd sectors: secondary component falls as hue rises
  function automatic logic sector_falling(input sector_t sec);
    return (sec == SEC_G_R) || (sec == SEC_B_G) || (sec == SEC_R_B);
  endfunction

endpackage

`default_nettype wire

// ===== src/hsl_to_rgb_converter_top.sv =====
// hsl to rgb converter, one hsla pixel in, one 8-bit rgba pixel out
// each accepted pixel passes through every pipeline stage before out_valid marks its result
// throughput: one pixel per clock; busy stays low, the result strobe cannot be held off
// reset: synchronous active-low rst_n clears the stage valid bits only
// depends on hsl2rgb_pkg and hsl_to_rgb_converter_top_defines.svh
`default_nettype none

`include "hsl_to_rgb_converter_top_defines.svh"

module hsl_to_rgb_converter_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [12:0] in_hue,
  input  wire logic [7:0]  in_saturation,
  input  wire logic [7:0]  in_luminance,
  input  wire logic [7:0]  in_alpha,
  output logic             out_valid,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_opacity
);

  localparam int ONE_W  = FRAC_BITS + 1;
  localparam int SUM_W  = FRAC_BITS + 2;
  localparam int PROD_W = FRAC_BITS + 11;
  localparam int Y_W    = FRAC_BITS + 4;
  localparam int MAG_W  = FRAC_BITS + 5;
  localparam int QW     = Y_W + MAG_W;
  localparam int DEPTH  = hsl2rgb_pkg::PIPE_DEPTH;

  localparam logic [ONE_W-1:0] ONE    = ONE_W'(64'd1 << FRAC_BITS);
  // 2^F = 255 * FRAC_Q + FRAC_R
  localparam logic [ONE_W-1:0] FRAC_Q = ONE_W'((64'd1 << FRAC_BITS) / 64'd255);
  localparam logic [7:0]       FRAC_R = 8'((64'd1 << FRAC_BITS) % 64'd255);
  // floor(y / 15) = (y * DIV15_MAGIC) >> DIV15_SHIFT for y below 2^(F+4)
  localparam int               DIV15_SHIFT = FRAC_BITS + 8;
  localparam logic [MAG_W-1:0] DIV15_MAGIC =
    MAG_W'(((64'd1 << DIV15_SHIFT) + 64'd14) / 64'd15);

  logic accept;
  logic [DEPTH-1:0] vld_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: hue sector split and the integer part of the byte-to-fraction scaling
  logic [12:0]             hue_w;
  hsl2rgb_pkg::sector_t    sec1_nxt;
  logic [9:0]              pos1_nxt;
  logic [ONE_W-1:0]        s_q1_r, l_q1_r;
  logic [15:0]             s_r1_r, l_r1_r;
  hsl2rgb_pkg::sector_t    sec1_r;
  logic [9:0]              pos1_r;
  logic [7:0]              a1_r;

  always_comb begin
    hue_w = (in_hue >= hsl2rgb_pkg::HUE_FULL) ? in_hue - hsl2rgb_pkg::HUE_FULL : in_hue;
    if (hue_w < hsl2rgb_pkg::sector_base(hsl2rgb_pkg::SEC_G_R)) begin
      sec1_nxt = hsl2rgb_pkg::SEC_R_G;
    end else if (hue_w < hsl2rgb_pkg::sector_base(hsl2rgb_pkg::SEC_G_B)) begin
      sec1_nxt = hsl2rgb_pkg::SEC_G_R;
    end else if (hue_w < hsl2rgb_pkg::sector_base(hsl2rgb_pkg::SEC_B_G)) begin
      sec1_nxt = hsl2rgb_pkg::SEC_G_B;
    end else if (hue_w < hsl2rgb_pkg::sector_base(hsl2rgb_pkg::SEC_B_R)) begin
      sec1_nxt = hsl2rgb_pkg::SEC_B_G;
    end else if (hue_w < hsl2rgb_pkg::sector_base(hsl2rgb_pkg::SEC_R_B)) begin
      sec1_nxt = hsl2rgb_pkg::SEC_B_R;
    end else begin
      sec1_nxt = hsl2rgb_pkg::SEC_R_B;
    end
    pos1_nxt = 10'(hue_w - hsl2rgb_pkg::sector_base(sec1_nxt));
  end

  // stage 2: finish ceil(v * 2^F / 255)
  logic [31:0]             s_div, l_div;
  logic [ONE_W-1:0]        s2_nxt, l2_nxt;
  logic [ONE_W-1:0]        s2_r, l2_r;
  hsl2rgb_pkg::sector_t    sec2_r;
  logic [9:0]              pos2_r;
  logic [7:0]              a2_r;

  always_comb begin
    s_div  = 32'(s_r1_r) * 32'(hsl2rgb_pkg::DIV255_MAGIC);
    l_div  = 32'(l_r1_r) * 32'(hsl2rgb_pkg::DIV255_MAGIC);
    s2_nxt = s_q1_r + ONE_W'(s_div[31:hsl2rgb_pkg::DIV255_SHIFT]);
    l2_nxt = l_q1_r + ONE_W'(l_div[31:hsl2rgb_pkg::DIV255_SHIFT]);
  end

  // stage 3: 1 - |2l - 1| and the position inside the sector
  logic [SUM_W-1:0]        twol;
  logic [SUM_W-1:0]        ldev;
  logic [ONE_W-1:0]        diff3_nxt;
  logic [9:0]              posx3_nxt;
  logic [ONE_W-1:0]        diff3_r, s3_r, l3_r;
  hsl2rgb_pkg::sector_t    sec3_r;
  logic [9:0]              posx3_r;
  logic [7:0]              a3_r;

  always_comb begin
    twol      = {l2_r, 1'b0};
    ldev      = (twol >= SUM_W'(ONE)) ? twol - SUM_W'(ONE) : SUM_W'(ONE) - twol;
    diff3_nxt = ONE - ONE_W'(ldev);
    posx3_nxt = hsl2rgb_pkg::sector_falling(sec2_r) ? hsl2rgb_pkg::SECTOR_SPAN - pos2_r
                                                     : pos2_r;
  end

  // stage 4: chroma
  logic [2*ONE_W-1:0]      cprod;
  logic [ONE_W-1:0]        chroma4_r, l4_r;
  hsl2rgb_pkg::sector_t    sec4_r;
  logic [9:0]              posx4_r;
  logic [7:0]              a4_r;

  assign cprod = (2*ONE_W)'(diff3_r) * (2*ONE_W)'(s3_r);

  // stage 5: chroma times position
  logic [PROD_W-1:0]       prod5_nxt;
  logic [PROD_W-1:0]       prod5_r;
  logic [ONE_W-1:0]        chroma5_r, l5_r;
  hsl2rgb_pkg::sector_t    sec5_r;
  logic [7:0]              a5_r;

  assign prod5_nxt = PROD_W'(chroma4_r) * PROD_W'(posx4_r);

  // stage 6: divide by 960 as a shift by 6 and a reciprocal multiply by 1/15, and form the offset l - chroma/2
  logic [Y_W-1:0]          y15;
  logic [QW-1:0]           q15;
  logic [ONE_W-1:0]        x6_r, chroma6_r, m6_r;
  hsl2rgb_pkg::sector_t    sec6_r;
  logic [7:0]              a6_r;

  always_comb begin
    y15 = prod5_r[FRAC_BITS+9:6];
    q15 = QW'(y15) * QW'(DIV15_MAGIC);
  end

  // stage 7: place components, add the offset, scale by 255
  logic [ONE_W-1:0]        comp_r, comp_g, comp_b;
  logic [7:0]              red_r, green_r, blue_r, opacity_r;

  function automatic logic [7:0] scale_chan(input logic [SUM_W-1:0] v);
    logic [SUM_W+7:0] w;
    logic [9:0]       hi;
    w  = {v, 8'd0} - (SUM_W+8)'(v);
    hi = w[SUM_W+7:FRAC_BITS];
    return (hi > 10'(hsl2rgb_pkg::CHAN_MAX)) ? hsl2rgb_pkg::CHAN_MAX : hi[7:0];
  endfunction

  always_comb begin
    unique case (sec6_r)
      hsl2rgb_pkg::SEC_R_G: begin
        comp_r = chroma6_r; comp_g = x6_r;      comp_b = '0;
      end
      hsl2rgb_pkg::SEC_G_R: begin
        comp_r = x6_r;      comp_g = chroma6_r; comp_b = '0;
      end
      hsl2rgb_pkg::SEC_G_B: begin
        comp_r = '0;        comp_g = chroma6_r; comp_b = x6_r;
      end
      hsl2rgb_pkg::SEC_B_G: begin
        comp_r = '0;        comp_g = x6_r;      comp_b = chroma6_r;
      end
      hsl2rgb_pkg::SEC_B_R: begin
        comp_r = x6_r;      comp_g = '0;        comp_b = chroma6_r;
      end
      hsl2rgb_pkg::SEC_R_B: begin
        comp_r = chroma6_r; comp_g = '0;        comp_b = x6_r;
      end
      default: begin
        comp_r = chroma6_r; comp_g = '0;        comp_b = x6_r;
      end
    endcase
  end

  // payload stages, no reset needed
  always_ff @(posedge clk) begin
    s_q1_r    <= ONE_W'(in_saturation) * FRAC_Q;
    l_q1_r    <= ONE_W'(in_luminance) * FRAC_Q;
    s_r1_r    <= 16'(in_saturation) * 16'(FRAC_R) + 16'd254;
    l_r1_r    <= 16'(in_luminance) * 16'(FRAC_R) + 16'd254;
    sec1_r    <= sec1_nxt;
    pos1_r    <= pos1_nxt;
    a1_r      <= in_alpha;

    s2_r      <= s2_nxt;
    l2_r      <= l2_nxt;
    sec2_r    <= sec1_r;
    pos2_r    <= pos1_r;
    a2_r      <= a1_r;

    diff3_r   <= diff3_nxt;
    s3_r      <= s2_r;
    l3_r      <= l2_r;
    sec3_r    <= sec2_r;
    posx3_r   <= posx3_nxt;
    a3_r      <= a2_r;

    chroma4_r <= cprod[2*FRAC_BITS:FRAC_BITS];
    l4_r      <= l3_r;
    sec4_r    <= sec3_r;
    posx4_r   <= posx3_r;
    a4_r      <= a3_r;

    prod5_r   <= prod5_nxt;
    chroma5_r <= chroma4_r;
    l5_r      <= l4_r;
    sec5_r    <= sec4_r;
    a5_r      <= a4_r;

    x6_r      <= ONE_W'(q15 >> DIV15_SHIFT);
    chroma6_r <= chroma5_r;
    m6_r      <= l5_r - (chroma5_r >> 1);
    sec6_r    <= sec5_r;
    a6_r      <= a5_r;

    red_r     <= scale_chan(SUM_W'(comp_r) + SUM_W'(m6_r));
    green_r   <= scale_chan(SUM_W'(comp_g) + SUM_W'(m6_r));
    blue_r    <= scale_chan(SUM_W'(comp_b) + SUM_W'(m6_r));
    opacity_r <= a6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], accept};
    end
  end

  assign out_valid   = vld_r[DEPTH-1];
  assign out_red     = red_r;
  assign out_green   = green_r;
  assign out_blue    = blue_r;
  assign out_opacity = opacity_r;

  logic grey_in;
  logic rgb_even;

  assign grey_in  = accept && (in_saturation == 8'd0);
  assign rgb_even = (out_red == out_green) && (out_green == out_blue);

  `HSL_ASSERT_LATER(a_latency, accept, DEPTH, out_valid, "accepted pixel did not come out on time")
  `HSL_ASSERT_NOW(a_no_phantom, out_valid, $past(accept, DEPTH), "result strobe without a transfer")
  `HSL_ASSERT_LATER(a_alpha, accept, DEPTH, out_opacity == $past(in_alpha, DEPTH), "alpha changed")
  `HSL_ASSERT_LATER(a_grey, grey_in, DEPTH, rgb_even, "grey pixel has uneven channels")

endmodule

`default_nettype wire

// ===== tb/hsl_to_rgb_converter_top_test.sv =====
// self-checking testbench for hsl_to_rgb_converter_top: directed and random hsla pixels,
// each rgba result checked against an in-bench fixed-point prediction
// depends on hsl2rgb_pkg and the converter rtl
`timescale 1ns / 100ps

module hsl_to_rgb_converter_top_test;

  localparam int FRAC_BITS = 16;
  localparam int PIXELS_PER_PHASE = 350;
  localparam int NUM_PHASES = 4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] opacity;
  } rgba_t;

  class pixel_scoreboard;
    rgba_t expected_q[$];
    int    mismatches;
    int    checked;

    function new();
      mismatches = 0;
      checked = 0;
    endfunction

    // byte fraction to fixed point, rounded up so grey levels come back exactly
    static function logic [63:0] byte_to_frac(input logic [7:0] v);
      logic [63:0] w;
      w = {56'd0, v};
      return ((w << FRAC_BITS) + 64'd254) / 64'd255;
    endfunction

    static function logic [7:0] to_channel(input logic [63:0] v);
      logic [63:0] c;
      c = (v * 64'd255) >> FRAC_BITS;
      return (c > {56'd0, hsl2rgb_pkg::CHAN_MAX}) ? hsl2rgb_pkg::CHAN_MAX : c[7:0];
    endfunction

    function rgba_t predict_rgba(input logic [12:0] hue, input logic [7:0] sat,
                                 input logic [7:0] lum, input logic [7:0] alpha);
      logic [63:0] one, h, s, l, twol, ldev, chroma, k, pos, x, m, r, g, b;
      hsl2rgb_pkg::sector_t sec;
      rgba_t       res;
      one = 64'd1 << FRAC_BITS;
      h = {51'd0, hue};
      s = byte_to_frac(sat);
      l = byte_to_frac(lum);
      if (h >= {51'd0, hsl2rgb_pkg::HUE_FULL}) begin
        h = h - {51'd0, hsl2rgb_pkg::HUE_FULL};
      end
      twol = 2 * l;
      ldev = (twol >= one) ? twol - one : one - twol;
      chroma = ((one - ldev) * s) >> FRAC_BITS;
      k = h / {54'd0, hsl2rgb_pkg::SECTOR_SPAN};
      pos = h % {54'd0, hsl2rgb_pkg::SECTOR_SPAN};
      sec = hsl2rgb_pkg::sector_t'(k[2:0]);
      // secondary rises through even sectors and falls through odd ones
      if (k[0] == 1'b0) begin
        x = (chroma * pos) / {54'd0, hsl2rgb_pkg::SECTOR_SPAN};
      end else begin
        x = (chroma * ({54'd0, hsl2rgb_pkg::SECTOR_SPAN} - pos))
            / {54'd0, hsl2rgb_pkg::SECTOR_SPAN};
      end
      case (sec)
        hsl2rgb_pkg::SEC_R_G: begin r = chroma; g = x;      b = '0;     end
        hsl2rgb_pkg::SEC_G_R: begin r = x;      g = chroma; b = '0;     end
        hsl2rgb_pkg::SEC_G_B: begin r = '0;     g = chroma; b = x;      end
        hsl2rgb_pkg::SEC_B_G: begin r = '0;     g = x;      b = chroma; end
        hsl2rgb_pkg::SEC_B_R: begin r = x;      g = '0;     b = chroma; end
        default: begin r = chroma; g = '0;     b = x;      end
      endcase
      m = l - (chroma >> 1);
      res.red = to_channel(r + m);
      res.green = to_channel(g + m);
      res.blue = to_channel(b + m);
      res.opacity = alpha;
      return res;
    endfunction

    function void note_pixel(input logic [12:0] hue, input logic [7:0] sat,
                             input logic [7:0] lum, input logic [7:0] alpha);
      expected_q.push_back(predict_rgba(hue, sat, lum, alpha));
    endfunction

    function void check_pixel(input rgba_t got);
      rgba_t want;
      if (expected_q.size() == 0) begin
        $error("result with no pixel outstanding: %0d %0d %0d %0d",
               got.red, got.green, got.blue, got.opacity);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        mismatches++;
      end
      if (got.opacity !== want.opacity) begin
        $error("opacity: expected %0d, got %0d", want.opacity, got.opacity);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [12:0] in_hue;
  logic [7:0]  in_saturation;
  logic [7:0]  in_luminance;
  logic [7:0]  in_alpha;
  logic        out_valid;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_opacity;

  pixel_scoreboard sb;
  int              wrapped_hues;

  hsl_to_rgb_converter_top #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_luminance (in_luminance),
    .in_alpha     (in_alpha),
    .out_valid    (out_valid),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_opacity  (out_opacity)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results are checked before the same edge's transfer is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        sb.check_pixel(rgba_t'{out_red, out_green, out_blue, out_opacity});
      end
      if (start && !busy) begin
        sb.note_pixel(in_hue, in_saturation, in_luminance, in_alpha);
        if (in_hue >= hsl2rgb_pkg::HUE_FULL) begin
          wrapped_hues++;
        end
      end
    end
  end

  task automatic send_pixel(input logic [12:0] hue, input logic [7:0] sat,
                            input logic [7:0] lum, input logic [7:0] alpha);
    @(negedge clk);
    start <= 1'b1;
    in_hue <= hue;
    in_saturation <= sat;
    in_luminance <= lum;
    in_alpha <= alpha;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_pixel(input int idle_pct);
    int          pick;
    logic [12:0] hue;
    logic [7:0]  sat;
    logic [7:0]  lum;
    pick = $urandom_range(99);
    if (pick < 10) begin
      hue = 13'($urandom_range(8191, 5760));
    end else if (pick < 20) begin
      // just around a sector boundary, including the wrap below zero
      hue = 13'(960 * $urandom_range(6) + $urandom_range(2)) - 13'd1;
    end else begin
      hue = 13'($urandom_range(5759));
    end
    sat = ($urandom_range(99) < 15) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                    : 8'($urandom_range(255));
    lum = ($urandom_range(99) < 15) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                    : 8'($urandom_range(255));
    if ($urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(4, 1)) idle_cycle();
    end
    send_pixel(hue, sat, lum, 8'($urandom_range(255)));
  endtask

  initial begin
    int idle_pcts[NUM_PHASES];
    sb = new();
    wrapped_hues = 0;
    idle_pcts = '{0, 56, 0, 11};
    rst_n = 1'b0;
    start = 1'b0;
    in_hue = '0;
    in_saturation = '0;
    in_luminance = '0;
    in_alpha = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sector edges at full saturation, mid lightness
    send_pixel(13'd0,    8'd255, 8'd128, 8'd0);
    send_pixel(13'd959,  8'd255, 8'd128, 8'd255);
    send_pixel(13'd960,  8'd255, 8'd128, 8'haa);
    send_pixel(13'd1919, 8'd255, 8'd128, 8'h55);
    send_pixel(13'd1920, 8'd255, 8'd128, 8'd1);
    send_pixel(13'd2880, 8'd255, 8'd128, 8'd128);
    send_pixel(13'd3840, 8'd255, 8'd128, 8'd127);
    send_pixel(13'd4800, 8'd255, 8'd128, 8'd254);
    send_pixel(13'd5759, 8'd255, 8'd128, 8'd2);
    // hue past a full turn wraps around
    send_pixel(13'd5760, 8'd255, 8'd128, 8'd3);
    send_pixel(13'd8191, 8'd255, 8'd127, 8'd4);
    // greys, black and white, then assorted saturation and lightness
    send_pixel(13'd1234, 8'd0,   8'd0,   8'd200);
    send_pixel(13'd4321, 8'd0,   8'd255, 8'd100);
    send_pixel(13'd2500, 8'd0,   8'd127, 8'd50);
    send_pixel(13'd3000, 8'd255, 8'd255, 8'd25);
    send_pixel(13'd100,  8'd255, 8'd0,   8'd12);
    send_pixel(13'd480,  8'd200, 8'd127, 8'd6);
    send_pixel(13'd4095, 8'd1,   8'd1,   8'd9);
    send_pixel(13'd2400, 8'd254, 8'd254, 8'd240);
    send_pixel(13'd5000, 8'd128, 8'd64,  8'd15);
    send_pixel(13'd1440, 8'd255, 8'd191, 8'd170);

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        send_random_pixel(idle_pcts[p]);
      end
    end
    @(negedge clk);
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (hsl2rgb_pkg::PIPE_DEPTH + 4) @(posedge clk);

    $display("checked %0d pixels over %0d sender idle settings, %0d with wrapped hue",
             sb.checked, NUM_PHASES, wrapped_hues);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d pixels outstanding", sb.expected_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/hsl2rgb_pkg.sv
src/hsl_to_rgb_converter_top.sv
tb/hsl_to_rgb_converter_top_test.sv
